// ===== rtl/bdq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque cells, control and top.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // What every cell of the row does on the current beat.
  typedef enum logic [1:0] {
    CELL_HOLD,         // keep the stored entry
    CELL_INSERT_FRONT, // cell 0 loads the value, the rest take the left neighbor
    CELL_WRITE_AT,     // only the addressed cell loads the value
    CELL_CLOSE_FROM    // cells at or above the index take the right neighbor
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e         cmd;
    logic [IDX_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage : bdq_pkg
`default_nettype wire

// ===== rtl/bdq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_cell
// One entry of the deque row; shifts to or from its neighbors on command.
// ----------------------------------------------------------------------------
module bdq_cell
  import bdq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire cell_ctl_t         ctl_i,
  input  wire logic [DATA_W-1:0] left_i,
  input  wire logic [DATA_W-1:0] right_i,
  output logic      [DATA_W-1:0] data_o,
  output logic      [DATA_W-1:0] next_o
);

  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CELL_INSERT_FRONT: data_d = (idx_i == '0) ? ctl_i.value : left_i;
      CELL_WRITE_AT:     if (idx_i == ctl_i.at) data_d = ctl_i.value;
      CELL_CLOSE_FROM:   if (idx_i >= ctl_i.at) data_d = right_i;
      default:           data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  assign next_o = en_i ? data_d : data_q;

endmodule : bdq_cell
`default_nettype wire

// ===== rtl/bdq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_ctrl
// Operation decoder and entry counter: checks bounds, sets status and the
// command broadcast to the cell row.
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire logic [POS_W-1:0]  pos_i,
  output cell_ctl_t              ctl_o,
  output status_e                status_o,
  output logic                   front_o,
  output logic      [CNT_W-1:0]  count_q_o,
  output logic      [CNT_W-1:0]  count_d_o
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty, out_of_range;

  assign full         = (count_q == CNT_W'(DEPTH));
  assign empty        = (count_q == '0);
  assign out_of_range = (32'(pos_i) >= 32'(count_q));

  always_comb begin
    ctl_o.cmd   = CELL_HOLD;
    ctl_o.at    = '0;
    ctl_o.value = value_i;
    status_o    = ST_OK;
    front_o     = 1'b0;
    count_d     = count_q;
    unique case (mode_e'(mode_i))
      MODE_PUSH_FRONT: begin
        front_o = 1'b1;
        if (full) begin
          status_o = ST_FULL;
        end else begin
          ctl_o.cmd = CELL_INSERT_FRONT;
          count_d   = count_q + CNT_W'(1);
        end
      end
      MODE_PUSH_BACK: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          ctl_o.cmd = CELL_WRITE_AT;
          ctl_o.at  = IDX_W'(count_q);
          count_d   = count_q + CNT_W'(1);
        end
      end
      MODE_POP_FRONT: begin
        front_o = 1'b1;
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          ctl_o.cmd = CELL_CLOSE_FROM;
          count_d   = count_q - CNT_W'(1);
        end
      end
      MODE_POP_BACK: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      MODE_REMOVE: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else if (out_of_range) begin
          status_o = ST_RANGE;
        end else begin
          ctl_o.cmd = CELL_CLOSE_FROM;
          ctl_o.at  = IDX_W'(pos_i);
          count_d   = count_q - CNT_W'(1);
        end
      end
      default: begin
        // Unused mode codes leave the list alone and report the back entry.
      end
    endcase
    if (!en_i) begin
      ctl_o.cmd = CELL_HOLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (en_i) begin
      count_q <= count_d;
    end
  end

  assign count_q_o = count_q;
  assign count_d_o = count_d;

endmodule : bdq_ctrl
`default_nettype wire

// ===== rtl/bounded_deque_with_positional_remove.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_remove
// Bounded double-ended queue of signed 32-bit values with removal at an index.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one operation per beat. tuser holds the mode
// (push front, push back, pop front, pop back, remove at position) and tdata
// holds the value to push and the position to remove. For every accepted beat
// the master stream returns exactly one result beat: tuser holds the status
// (ok, empty, full, position out of range) and tdata holds the value now at
// the front (after front operations) or back (otherwise), its valid flag, the
// entry count and an empty flag.
//
// The list lives in a row of DEPTH cells. On an accepted beat every cell
// loads its own value, a neighbor or the pushed value, so any operation,
// including a removal in the middle, completes at the edge that accepts
// its beat. The result is registered at that edge; one beat is taken per
// cycle unless the receiver stalls. The cell row update followed by the end
// selection sets the clock. A single output register separates the two
// sides; if the receiver stalls, s_axis_tready_o drops until the waiting
// result is taken. Reset clears the entry count and the output valid; cell
// contents are not reset, since only counted entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_positional_remove
  import bdq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Operation beats.
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [39:0] s_axis_tdata_i,  // item_value[31:0], position[35:32], zero pad
  input  wire logic [2:0]  s_axis_tuser_i,  // mode[2:0]
  // Result beats.
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [39:0] m_axis_tdata_o,  // end_value[31:0], end_valid[32],
                                            // entry_count[37:33], is_empty[38], zero pad
  output logic      [1:0]  m_axis_tuser_o   // status[1:0]
);

  logic              accept;
  cell_ctl_t         cell_ctl;
  status_e           status;
  logic              front_end;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DATA_W-1:0] cell_next [DEPTH];

  // Output register.
  logic              out_valid_q;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_end_valid_q;
  logic [COUNT_W-1:0] out_count_q;
  logic              out_empty_q;

  logic              end_valid;
  logic [DATA_W-1:0] end_value;
  logic [IDX_W-1:0]  end_idx;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  bdq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (accept),
    .mode_i    (s_axis_tuser_i[MODE_W-1:0]),
    .value_i   (s_axis_tdata_i[DATA_W-1:0]),
    .pos_i     (s_axis_tdata_i[DATA_W+POS_W-1:DATA_W]),
    .ctl_o     (cell_ctl),
    .status_o  (status),
    .front_o   (front_end),
    .count_q_o (count_q),
    .count_d_o (count_d)
  );

  // The row of cells. The first cell has no left neighbor and the last has
  // no right neighbor; those inputs are never selected for a counted entry.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = cell_ctl.value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    bdq_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (accept),
      .idx_i   (IDX_W'(i)),
      .ctl_i   (cell_ctl),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .next_o  (cell_next[i])
    );
  end

  // Pick the new front or back entry from the updated row.
  assign end_valid = (count_d != '0);
  assign end_idx   = front_end ? '0 : IDX_W'(count_d - CNT_W'(1));
  assign end_value = end_valid ? cell_next[end_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_status_q    <= status;
      out_value_q     <= end_value;
      out_end_valid_q <= end_valid;
      out_count_q     <= COUNT_W'(count_d);
      out_empty_q     <= !end_valid;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_empty_q, out_count_q, out_end_valid_q, out_value_q};

  // The count never passes the capacity of the row.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count above capacity");

  // A successful push adds exactly one entry.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status == ST_OK &&
    (s_axis_tuser_i == MODE_PUSH_FRONT || s_axis_tuser_i == MODE_PUSH_BACK)
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not add one entry");

  // A refused operation leaves the count alone.
  a_refused_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && status != ST_OK |=> $stable(count_q))
    else $error("refused operation changed the count");

  // A pending result reports empty exactly when it carries no entry.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_empty_q == !out_end_valid_q) &&
                    (out_empty_q == (out_count_q == '0)))
    else $error("empty flag disagrees with result");

endmodule : bounded_deque_with_positional_remove
`default_nettype wire
